// File: rtl/core/bfa_pkg.sv
`timescale 1ns / 1ps

package bfa_pkg;

  // geometry
  localparam int FRAME_CAPACITY_DEF = 131072;
  localparam int WORD_BITS          = 32;
  localparam int FRAME_SHIFT        = 12;
  localparam int ADDR_W             = 32;
  localparam int COUNT_W            = 18;
  localparam int OPC_W              = 2;
  localparam int UKB_W              = 22;
  localparam int CFG_ADDR_W         = 2;
  localparam int CFG_DATA_W         = 32;

  // frame arithmetic for init, wide enough for a 4 GB map plus one
  localparam int SIZE_W = 21;
  localparam logic [SIZE_W-1:0] LOW_FRAMES      = 21'd256;
  localparam logic [SIZE_W-1:0] DEFAULT_FRAMES  = 21'd4096;
  localparam logic [SIZE_W-1:0] MAX_SIZE_FRAMES = 21'h0F_FFFF;

  localparam logic [ADDR_W-1:0] KERNEL_END_RST = 32'h0010_0000;

  typedef enum logic [OPC_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } bfa_op_t;

  localparam logic [CFG_ADDR_W-1:0] CFG_MEM_MAP_VALID = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_UPPER_MEM_KB  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_KERNEL_END    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT_CALC,
    S_INIT_FILL,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_FREE_RD,
    S_FREE_CHK,
    S_DONE
  } bfa_state_t;

  typedef struct packed {
    logic capture;
    logic init_calc;
    logic init_fill;
    logic alloc_read;
    logic alloc_check;
    logic free_check;
    logic load_result;
  } bfa_cmd_t;

  typedef struct packed {
    logic fill_done;
    logic alloc_exhausted;
    logic word_full;
    logic free_in_range;
    logic slot_free;
  } bfa_status_t;

endpackage

// File: rtl/core/bfa_req_if.sv
`timescale 1ns / 1ps

interface bfa_req_if;
  logic                            valid;
  logic                            ready;
  logic [bfa_pkg::OPC_W-1:0]       opcode;
  logic [bfa_pkg::ADDR_W-1:0]      free_address;

  modport source (output valid, output opcode, output free_address, input ready);
  modport sink   (input valid, input opcode, input free_address, output ready);
endinterface

// File: rtl/core/bfa_rsp_if.sv
`timescale 1ns / 1ps

interface bfa_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [bfa_pkg::ADDR_W-1:0]      frame_address;
  logic                            success;
  logic [bfa_pkg::COUNT_W-1:0]     free_count;
  logic [bfa_pkg::COUNT_W-1:0]     frame_count;

  modport source (output valid, output frame_address, output success,
                  output free_count, output frame_count, input ready);
  modport sink   (input valid, input frame_address, input success,
                  input free_count, input frame_count, output ready);
endinterface

// File: rtl/core/bfa_cfg_if.sv
`timescale 1ns / 1ps

interface bfa_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bfa_pkg::CFG_ADDR_W-1:0]    addr;
  logic [bfa_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// File: rtl/core/bfa_ram.sv
`timescale 1ns / 1ps

module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/bfa_ctrl.sv
`timescale 1ns / 1ps

module bfa_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic [bfa_pkg::OPC_W-1:0] req_opcode,
  output logic                      req_ready,
  input  bfa_pkg::bfa_status_t      status,
  output bfa_pkg::bfa_cmd_t         cmd
);

  bfa_pkg::bfa_state_t state;
  bfa_pkg::bfa_state_t state_next;
  logic                accept;

  assign req_ready = (state == bfa_pkg::S_IDLE);
  assign accept    = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bfa_pkg::S_IDLE: begin
        if (accept) begin
          unique case (req_opcode)
            bfa_pkg::OP_INIT:  state_next = bfa_pkg::S_INIT_CALC;
            bfa_pkg::OP_ALLOC: state_next = bfa_pkg::S_ALLOC_RD;
            bfa_pkg::OP_FREE:  state_next = bfa_pkg::S_FREE_RD;
            default:           state_next = bfa_pkg::S_DONE;
          endcase
        end
      end
      bfa_pkg::S_INIT_CALC: state_next = bfa_pkg::S_INIT_FILL;
      bfa_pkg::S_INIT_FILL: begin
        if (status.fill_done) begin
          state_next = bfa_pkg::S_DONE;
        end
      end
      bfa_pkg::S_ALLOC_RD: begin
        state_next = status.alloc_exhausted ? bfa_pkg::S_DONE : bfa_pkg::S_ALLOC_CHK;
      end
      bfa_pkg::S_ALLOC_CHK: begin
        state_next = status.word_full ? bfa_pkg::S_ALLOC_RD : bfa_pkg::S_DONE;
      end
      bfa_pkg::S_FREE_RD: begin
        state_next = status.free_in_range ? bfa_pkg::S_FREE_CHK : bfa_pkg::S_DONE;
      end
      bfa_pkg::S_FREE_CHK: state_next = bfa_pkg::S_DONE;
      bfa_pkg::S_DONE: begin
        if (status.slot_free) begin
          state_next = bfa_pkg::S_IDLE;
        end
      end
      default: state_next = bfa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.capture     = accept;
    cmd.init_calc   = (state == bfa_pkg::S_INIT_CALC);
    cmd.init_fill   = (state == bfa_pkg::S_INIT_FILL) && !status.fill_done;
    cmd.alloc_read  = (state == bfa_pkg::S_ALLOC_RD);
    cmd.alloc_check = (state == bfa_pkg::S_ALLOC_CHK);
    cmd.free_check  = (state == bfa_pkg::S_FREE_CHK);
    cmd.load_result = (state == bfa_pkg::S_DONE) && status.slot_free;
  end

endmodule

// File: rtl/core/bfa_datapath.sv
`timescale 1ns / 1ps

module bfa_datapath #(
  parameter int FRAME_CAPACITY = bfa_pkg::FRAME_CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [bfa_pkg::ADDR_W-1:0] req_free_address,
  bfa_cfg_if.sink                    cfg,
  bfa_rsp_if.source                  rsp,
  input  bfa_pkg::bfa_cmd_t          cmd,
  output bfa_pkg::bfa_status_t       status
);

  localparam int MAP_WORDS = (FRAME_CAPACITY + bfa_pkg::WORD_BITS - 1) / bfa_pkg::WORD_BITS;
  localparam int WADDR_W   = $clog2(MAP_WORDS);
  localparam int HINT_W    = $clog2(MAP_WORDS + 1);
  localparam int CNT_W     = $clog2(FRAME_CAPACITY + 1);
  localparam int SW        = bfa_pkg::SIZE_W;
  localparam int AW        = bfa_pkg::ADDR_W;
  localparam int FS        = bfa_pkg::FRAME_SHIFT;
  localparam logic [SW-1:0] CAP_FRAMES = SW'(FRAME_CAPACITY);

  // configuration registers
  logic                     mem_map_valid;
  logic [bfa_pkg::UKB_W-1:0] upper_memory_kb;
  logic [AW-1:0]            kernel_end_address;

  // map state
  logic [AW-1:0]     free_addr;
  logic [CNT_W-1:0]  managed, managed_next;
  logic [CNT_W-1:0]  lo, lo_next;
  logic [CNT_W-1:0]  free_cnt, free_cnt_next;
  logic [HINT_W-1:0] word_count, word_count_next;
  logic [HINT_W-1:0] hint, hint_next;
  logic [HINT_W-1:0] fill_idx, fill_idx_next;
  logic [AW-1:0]     res_addr, res_addr_next;
  logic              res_ok, res_ok_next;

  // ram port
  logic               ram_we;
  logic [WADDR_W-1:0] ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata, ram_rdata;

  // init arithmetic
  logic [SW-1:0] mm_raw, size_frames, capped, kend, lo_calc;

  // fill word
  logic [HINT_W-1:0] lo_word, hi_word;
  logic [31:0]       free_lo_mask, free_hi_mask;

  // search and free
  logic [4:0]           zero_bit;
  logic [WADDR_W+4:0]   alloc_frame;
  logic                 alloc_ok;
  logic [AW-FS-1:0]     fnum;
  logic [WADDR_W-1:0]   fword;
  logic [4:0]           fbit;

  bfa_ram #(
    .WIDTH(32),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // config port never stalls
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_map_valid      <= 1'b0;
      upper_memory_kb    <= '0;
      kernel_end_address <= bfa_pkg::KERNEL_END_RST;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        bfa_pkg::CFG_MEM_MAP_VALID: mem_map_valid      <= cfg.data[0];
        bfa_pkg::CFG_UPPER_MEM_KB:  upper_memory_kb    <= cfg.data[bfa_pkg::UKB_W-1:0];
        bfa_pkg::CFG_KERNEL_END:    kernel_end_address <= cfg.data;
        default: ;
      endcase
    end
  end

  // frame count and low free bound
  always_comb begin
    mm_raw      = bfa_pkg::LOW_FRAMES + SW'(upper_memory_kb >> 2);
    size_frames = !mem_map_valid ? bfa_pkg::DEFAULT_FRAMES :
                  (mm_raw > bfa_pkg::MAX_SIZE_FRAMES) ? bfa_pkg::MAX_SIZE_FRAMES : mm_raw;
    capped      = (size_frames > CAP_FRAMES) ? CAP_FRAMES : size_frames;
    kend        = SW'(kernel_end_address[AW-1:FS]) + SW'(|kernel_end_address[FS-1:0]);
    lo_calc     = bfa_pkg::LOW_FRAMES;
    if (kend > bfa_pkg::LOW_FRAMES) begin
      lo_calc = (kend > capped) ? capped : kend;
    end
  end

  // used word for the fill sweep
  always_comb begin
    lo_word = HINT_W'(lo >> 5);
    hi_word = HINT_W'(managed >> 5);
    if (fill_idx > lo_word) begin
      free_lo_mask = '1;
    end else if (fill_idx == lo_word) begin
      free_lo_mask = 32'hFFFF_FFFF << lo[4:0];
    end else begin
      free_lo_mask = '0;
    end
    if (fill_idx < hi_word) begin
      free_hi_mask = '1;
    end else if (fill_idx == hi_word) begin
      free_hi_mask = ~(32'hFFFF_FFFF << managed[4:0]);
    end else begin
      free_hi_mask = '0;
    end
  end

  // lowest clear bit of the word read
  always_comb begin
    zero_bit = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!ram_rdata[i]) begin
        zero_bit = 5'(i);
      end
    end
  end

  assign alloc_frame = {hint[WADDR_W-1:0], zero_bit};
  assign alloc_ok    = 32'(alloc_frame) < 32'(managed);
  assign fnum        = free_addr[AW-1:FS];
  assign fword       = fnum[WADDR_W+4:5];
  assign fbit        = fnum[4:0];

  assign ram_raddr = cmd.alloc_read ? hint[WADDR_W-1:0] : fword;

  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = fword;
    ram_wdata       = ram_rdata & ~(32'd1 << fbit);
    managed_next    = managed;
    lo_next         = lo;
    free_cnt_next   = free_cnt;
    word_count_next = word_count;
    hint_next       = hint;
    fill_idx_next   = fill_idx;
    res_addr_next   = res_addr;
    res_ok_next     = res_ok;

    if (cmd.capture) begin
      res_addr_next = '0;
      res_ok_next   = 1'b0;
    end

    if (cmd.init_calc) begin
      managed_next    = CNT_W'(capped);
      lo_next         = CNT_W'(lo_calc);
      free_cnt_next   = (lo_calc < capped) ? CNT_W'(capped - lo_calc) : '0;
      word_count_next = HINT_W'((capped + SW'(31)) >> 5);
      hint_next       = HINT_W'(lo_calc >> 5);
      fill_idx_next   = '0;
      res_ok_next     = 1'b1;
    end

    if (cmd.init_fill) begin
      ram_we        = 1'b1;
      ram_waddr     = fill_idx[WADDR_W-1:0];
      ram_wdata     = ~(free_lo_mask & free_hi_mask);
      fill_idx_next = fill_idx + HINT_W'(1);
    end

    if (cmd.alloc_check) begin
      if (&ram_rdata) begin
        hint_next = hint + HINT_W'(1);
      end else if (alloc_ok) begin
        ram_we        = 1'b1;
        ram_waddr     = hint[WADDR_W-1:0];
        ram_wdata     = ram_rdata | (32'd1 << zero_bit);
        free_cnt_next = free_cnt - CNT_W'(1);
        res_addr_next = 32'(alloc_frame) << FS;
        res_ok_next   = 1'b1;
      end
    end

    if (cmd.free_check && ram_rdata[fbit]) begin
      ram_we        = 1'b1;
      free_cnt_next = free_cnt + CNT_W'(1);
      res_ok_next   = 1'b1;
      if (HINT_W'(fword) < hint) begin
        hint_next = HINT_W'(fword);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      managed    <= '0;
      free_cnt   <= '0;
      word_count <= '0;
      hint       <= '0;
      fill_idx   <= '0;
      lo         <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      managed    <= managed_next;
      free_cnt   <= free_cnt_next;
      word_count <= word_count_next;
      hint       <= hint_next;
      fill_idx   <= fill_idx_next;
      lo         <= lo_next;
      if (cmd.load_result) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_addr <= res_addr_next;
    res_ok   <= res_ok_next;
    if (cmd.capture) begin
      free_addr <= req_free_address;
    end
    if (cmd.load_result) begin
      rsp.frame_address <= res_addr;
      rsp.success       <= res_ok;
      rsp.free_count    <= bfa_pkg::COUNT_W'(free_cnt);
      rsp.frame_count   <= bfa_pkg::COUNT_W'(managed);
    end
  end

  always_comb begin
    status                 = '0;
    status.fill_done       = (fill_idx >= word_count);
    status.alloc_exhausted = (hint >= word_count);
    status.word_full       = &ram_rdata;
    status.free_in_range   = 32'(fnum) < 32'(managed);
    status.slot_free       = !rsp.valid || rsp.ready;
  end

endmodule

// File: rtl/core/bitmap_frame_allocator.sv
`timescale 1ns / 1ps

// First-fit page frame allocator over a bitmap of 4 KB frames, one used bit per
// frame, FRAME_CAPACITY frames kept in a one-port-write/one-port-read RAM of
// 32-bit words. Items on req: init (opcode 0) sizes the map from the config
// registers and rebuilds it, alloc (1) returns the lowest free frame's byte
// address, free (2) releases one frame. Each item gives one result on rsp with
// the free and managed frame counts. Timing is set by the bitmap RAM and its
// registered read: alloc reads and checks the word at the search hint, and
// reads and checks once more for each full word it steps over; the hint
// marks the lowest word that may hold a free bit, so steady allocation rarely
// skips more than one word. Free reads and checks the frame's word, skipping
// the check when the frame is out of range. Init sizes the map, then writes
// one RAM word per cycle over ceil(frames/32) words. No clearing pass
// runs after reset: with a frame count of zero nothing reads the RAM until the
// first init has rewritten every word it can reach. A new item is accepted
// while an earlier result still waits on rsp; the block then holds the new
// result until the output register empties. Config writes are always taken
// and must only be issued while the block is idle.

module bitmap_frame_allocator #(
  parameter int FRAME_CAPACITY = bfa_pkg::FRAME_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bfa_req_if.sink    req,
  bfa_rsp_if.source  rsp,
  bfa_cfg_if.sink    cfg
);

  // control and status between the sequencer and the map datapath
  bfa_pkg::bfa_cmd_t    cmd;
  bfa_pkg::bfa_status_t status;

  // sequencer: one item at a time, walks init sweep, search or free check
  bfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_opcode(req.opcode),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // bitmap ram, counters, search hint, config and result registers
  bfa_datapath #(
    .FRAME_CAPACITY(FRAME_CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .req_free_address(req.free_address),
    .cfg             (cfg),
    .rsp             (rsp),
    .cmd             (cmd),
    .status          (status)
  );

endmodule

// File: rtl/core/bfa_checker.sv
`timescale 1ns / 1ps

module bfa_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [bfa_pkg::ADDR_W-1:0]   rsp_frame_address,
  input logic                         rsp_success,
  input logic [bfa_pkg::COUNT_W-1:0]  rsp_free_count
);

  // items taken but whose result is not yet delivered
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
    end
  end

  a_no_orphan_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result shown with no item pending");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two items in flight");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_success |-> rsp_frame_address == '0)
    else $error("failed item carries a frame address");

  a_frame_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_frame_address[bfa_pkg::FRAME_SHIFT-1:0] == '0)
    else $error("frame address not frame aligned");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_address)
      && $stable(rsp_success) && $stable(rsp_free_count))
    else $error("stalled result changed");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_frame_address(rsp.frame_address),
  .rsp_success      (rsp.success),
  .rsp_free_count   (rsp.free_count)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bfa_pkg::*;

  localparam int CAPACITY     = FRAME_CAPACITY_DEF;
  localparam int MAP_WORDS    = CAPACITY / WORD_BITS;
  localparam int RANDOM_ITEMS = 1850;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam logic [OPC_W-1:0]  OP_UNUSED   = 2'd3;
  localparam logic [ADDR_W-1:0] LOW_MEM_END = 32'h0010_0000;

  // one result item as it leaves on rsp
  typedef struct packed {
    logic [ADDR_W-1:0]  frame_address;
    logic               success;
    logic [COUNT_W-1:0] free_count;
    logic [COUNT_W-1:0] frame_count;
  } frame_result_t;

  typedef enum logic {ROW_REG, ROW_REQ} row_kind_e;

  // one row of the directed script
  typedef struct packed {
    row_kind_e         kind;
    logic [OPC_W-1:0]  code;   // register index or opcode
    logic [ADDR_W-1:0] value;  // register data or free address
    logic              typed;  // result written into the row by hand
    frame_result_t     want;
  } script_row_t;

  logic clk;
  logic rst;

  bfa_req_if req_if ();
  bfa_rsp_if rsp_if ();
  bfa_cfg_if cfg_if ();

  bitmap_frame_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  // shadow copy of the allocator: bitmap, counters and registers
  logic [WORD_BITS-1:0] used_word [MAP_WORDS];
  int unsigned          open_frames;
  int unsigned          managed;
  int unsigned          lowest_open;  // every word below this one is full
  logic                 cfg_map_valid;
  logic [UKB_W-1:0]     cfg_upper_kb;
  logic [ADDR_W-1:0]    cfg_kernel_end;

  frame_result_t replies_due [$];   // results owed by the block, oldest first
  logic [ADDR_W-1:0] granted [$];   // frames handed out since the last init
  script_row_t script [$];
  int bad_replies = 0;
  int send_calm   = 0;
  int recv_calm   = 0;

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop; the slowest legal run ends well before it
  initial begin
    #80_000_000;
    $display("Verification failed");
    $finish;
  end

  // wait before the next item: mostly random, with runs of back-to-back items
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      calm = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // apply one request item to the shadow bitmap and return its result
  function automatic frame_result_t bitmap_apply(logic [OPC_W-1:0] op,
                                                 logic [ADDR_W-1:0] addr);
    frame_result_t r;
    logic [63:0]   size_bytes;
    logic [63:0]   frames;
    logic [63:0]   kend;
    int unsigned   lo;
    int unsigned   f;
    int unsigned   w;
    int unsigned   b;
    r = '0;
    case (op)
      OP_INIT: begin
        // 16 MB unless the memory map is valid; saturate, then cap at capacity
        size_bytes = 64'd16 * 1024 * 1024;
        if (cfg_map_valid) begin
          size_bytes = 64'h10_0000 + {42'd0, cfg_upper_kb} * 64'd1024;
          if (size_bytes > 64'hFFFF_FFFF) size_bytes = 64'hFFFF_FFFF;
        end
        frames = size_bytes / PAGE_BYTES;
        if (frames > CAPACITY) frames = CAPACITY;
        managed = frames[31:0];
        for (w = 0; w < MAP_WORDS; w++) used_word[w] = '1;
        // kernel end rounded up to a frame, no wrap
        kend = ({32'd0, cfg_kernel_end} + 64'd4095) / 64'd4096;
        lo = 256;
        if (kend > lo) lo = (kend > frames) ? frames[31:0] : kend[31:0];
        if (lo < managed) begin
          for (f = lo; f < managed; f++) used_word[f / 32][f % 32] = 1'b0;
          open_frames = managed - lo;
        end else begin
          open_frames = 0;
        end
        lowest_open = 0;
        r.success = 1'b1;
      end
      OP_ALLOC: begin
        // first fit: lowest clear bit, and it must lie below the frame count
        for (w = lowest_open; w < MAP_WORDS; w++)
          if (used_word[w] != '1) break;
        lowest_open = w;
        if (w < MAP_WORDS) begin
          for (b = 0; b < WORD_BITS; b++)
            if (!used_word[w][b]) break;
          f = w * 32 + b;
          if (f < managed) begin
            used_word[w][b] = 1'b1;
            open_frames--;
            r.frame_address = f * PAGE_BYTES;
            r.success = 1'b1;
          end
        end
      end
      OP_FREE: begin
        f = addr >> FRAME_SHIFT;
        if (f < managed) begin
          w = f / 32;
          b = f % 32;
          if (used_word[w][b]) begin
            used_word[w][b] = 1'b0;
            open_frames++;
            r.success = 1'b1;
            if (w < lowest_open) lowest_open = w;
          end
        end
      end
      default: ;
    endcase
    r.free_count  = COUNT_W'(open_frames);
    r.frame_count = COUNT_W'(managed);
    return r;
  endfunction

  function automatic void plan_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    script_row_t r;
    r = '0;
    r.kind  = ROW_REG;
    r.code  = idx;
    r.value = data;
    script.push_back(r);
  endfunction

  function automatic void plan_req(logic [OPC_W-1:0] op, logic [ADDR_W-1:0] addr);
    script_row_t r;
    r = '0;
    r.kind  = ROW_REQ;
    r.code  = op;
    r.value = addr;
    script.push_back(r);
  endfunction

  function automatic void plan_chk(logic [OPC_W-1:0] op, logic [ADDR_W-1:0] addr,
                                   logic [ADDR_W-1:0] fa, logic ok,
                                   int unsigned fc, int unsigned mc);
    script_row_t r;
    r = '0;
    r.kind  = ROW_REQ;
    r.code  = op;
    r.value = addr;
    r.typed = 1'b1;
    r.want  = {fa, ok, COUNT_W'(fc), COUNT_W'(mc)};
    script.push_back(r);
  endfunction

  // config write; the block must be idle
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_MEM_MAP_VALID: cfg_map_valid  = data[0];
      CFG_UPPER_MEM_KB:  cfg_upper_kb   = data[UKB_W-1:0];
      CFG_KERNEL_END:    cfg_kernel_end = data;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // send one item; the shadow state moves at the accepting edge
  task automatic issue_request(logic [OPC_W-1:0] op, logic [ADDR_W-1:0] addr,
                               logic typed, frame_result_t want);
    int gap;
    frame_result_t got;
    gap = pick_wait(send_calm);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.opcode       <= op;
    req_if.free_address <= addr;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    got = bitmap_apply(op, addr);
    if (op == OP_INIT) granted.delete();
    else if (op == OP_ALLOC && got.success) granted.push_back(got.frame_address);
    replies_due.push_back(typed ? want : got);
  endtask

  // every item answers, so idle means nothing owed
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int          rand_count;
    int          phase_len;
    int          n;
    int          sel;
    int          pick;
    int unsigned span;
    int unsigned idx;
    logic        map_on;
    logic [UKB_W-1:0]  ukb;
    logic [ADDR_W-1:0] kend;
    logic [ADDR_W-1:0] addr;
    logic [OPC_W-1:0]  op;

    // all inputs known from time zero
    rst                 = 1'b1;
    req_if.valid        = 1'b0;
    req_if.opcode       = OP_INIT;
    req_if.free_address = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.addr         = '0;
    cfg_if.data         = '0;

    // shadow state after reset
    for (int w = 0; w < MAP_WORDS; w++) used_word[w] = '1;
    open_frames    = 0;
    managed        = 0;
    lowest_open    = 0;
    cfg_map_valid  = 1'b0;
    cfg_upper_kb   = '0;
    cfg_kernel_end = KERNEL_END_RST;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // use before init: zero frames, every alloc, free and unused opcode fails
    plan_chk(OP_ALLOC,  32'h0,          32'h0, 1'b0, 0, 0);
    plan_chk(OP_FREE,   LOW_MEM_END,    32'h0, 1'b0, 0, 0);
    plan_chk(OP_UNUSED, 32'hFFFF_FFFF,  32'h0, 1'b0, 0, 0);
    // reset registers: 16 MB, kernel ends at 1 MB
    plan_chk(OP_INIT,   32'h0,          32'h0, 1'b1, 3840, 4096);
    plan_chk(OP_ALLOC,  32'h0,          LOW_MEM_END, 1'b1, 3839, 4096);
    plan_chk(OP_FREE,   LOW_MEM_END,    32'h0, 1'b1, 3840, 4096);
    // double free
    plan_chk(OP_FREE,   LOW_MEM_END,    32'h0, 1'b0, 3840, 4096);
    // frame zero freed by hand, then handed out at address zero with success
    plan_chk(OP_FREE,   32'h0,          32'h0, 1'b1, 3841, 4096);
    plan_chk(OP_ALLOC,  32'h0,          32'h0, 1'b1, 3840, 4096);
    // out of range, then a free of the top frame, which is not in use
    plan_chk(OP_FREE,   32'hFFFF_FFFF,  32'h0, 1'b0, 3840, 4096);
    plan_chk(OP_ALLOC,  32'h0,          LOW_MEM_END, 1'b1, 3839, 4096);
    plan_chk(OP_FREE,   32'h00FF_F000,  32'h0, 1'b0, 3839, 4096);
    // map valid, no upper memory, kernel end zero: nothing free
    plan_reg(CFG_MEM_MAP_VALID, 32'd1);
    plan_reg(CFG_KERNEL_END,    32'h0);
    plan_chk(OP_INIT,   32'h0,          32'h0, 1'b1, 0, 256);
    plan_chk(OP_ALLOC,  32'h0,          32'h0, 1'b0, 0, 256);
    // low memory frame released like any other
    plan_chk(OP_FREE,   32'h000F_F000,  32'h0, 1'b1, 1, 256);
    plan_chk(OP_ALLOC,  32'h0,          32'h000F_F000, 1'b1, 0, 256);
    // size saturates and caps at capacity, kernel end at the top of the space
    plan_reg(CFG_UPPER_MEM_KB,  32'h003F_FFFF);
    plan_reg(CFG_KERNEL_END,    32'hFFFF_FFFF);
    plan_chk(OP_INIT,   32'h0,          32'h0, 1'b1, 0, CAPACITY);
    plan_chk(OP_FREE,   32'h1FFF_F000,  32'h0, 1'b1, 1, CAPACITY);
    plan_chk(OP_ALLOC,  32'h0,          32'h1FFF_F000, 1'b1, 0, CAPACITY);
    // kernel end one byte past 1 MB rounds up to frame 257
    plan_reg(CFG_UPPER_MEM_KB,  32'd1024);
    plan_reg(CFG_KERNEL_END,    32'h0010_0001);
    plan_chk(OP_INIT,   32'h0,          32'h0, 1'b1, 255, 512);
    plan_chk(OP_ALLOC,  32'h0,          32'h0010_1000, 1'b1, 254, 512);
    // frame inside the kernel released
    plan_chk(OP_FREE,   LOW_MEM_END,    32'h0, 1'b1, 255, 512);
    plan_chk(OP_ALLOC,  32'h0,          LOW_MEM_END, 1'b1, 254, 512);
    plan_req(OP_FREE,   32'h001F_FFFF);
    plan_req(OP_ALLOC,  32'h0);

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(script[i].code, script[i].value);
      end else begin
        issue_request(script[i].code, script[i].value, script[i].typed, script[i].want);
      end
    end

    // random phases: new layout, init, then a run of mostly allocs and frees, with the odd init or unused opcode
    rand_count = 0;
    while (rand_count < RANDOM_ITEMS) begin
      wait_idle();
      sel    = $urandom_range(0, 15);
      map_on = (sel >= 3);
      // large layouts are rare since init writes every map word below the frame count
      ukb    = (sel <= 3) ? UKB_W'($urandom) : UKB_W'($urandom_range(0, 8192));
      span   = map_on ? (ukb >> 2) + 256 : 4096;
      if (span > CAPACITY) span = CAPACITY;
      case ($urandom_range(0, 7))
        0:       kend = '0;
        1:       kend = $urandom;
        2:       kend = span * PAGE_BYTES;
        default: kend = $urandom_range(LOW_MEM_END, span * PAGE_BYTES + 32'h2000);
      endcase
      write_reg(CFG_MEM_MAP_VALID, {31'd0, map_on});
      write_reg(CFG_UPPER_MEM_KB,  {10'd0, ukb});
      write_reg(CFG_KERNEL_END,    kend);
      issue_request(OP_INIT, $urandom, 1'b0, '0);
      rand_count++;

      phase_len = $urandom_range(20, 80);
      for (n = 0; n < phase_len && rand_count < RANDOM_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        addr = $urandom;
        if (pick < 3)       op = OP_INIT;
        else if (pick < 6)  op = OP_UNUSED;
        else if (pick < 52) op = OP_ALLOC;
        else begin
          op   = OP_FREE;
          pick = $urandom_range(0, 9);
          // mostly hand back a granted frame or a frame near the range, else any address
          if (pick < 5 && granted.size() > 0) begin
            idx  = $urandom_range(0, granted.size() - 1);
            addr = granted[idx] | $urandom_range(0, 4095);
            granted.delete(idx);
          end else if (pick < 8) begin
            addr = ($urandom_range(0, managed + 1) << FRAME_SHIFT) | $urandom_range(0, 4095);
          end
        end
        issue_request(op, addr, 1'b0, '0);
        rand_count++;
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (bad_replies == 0 && replies_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result side: random stalls, each item checked against the oldest owed result
  initial begin : result_monitor
    int stall;
    frame_result_t got;
    frame_result_t want;
    rsp_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = pick_wait(recv_calm);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_if.valid) @(posedge clk);
      got = {rsp_if.frame_address, rsp_if.success, rsp_if.free_count, rsp_if.frame_count};
      if (replies_due.size() == 0) begin
        if (bad_replies < 10)
          $display("%0t: result with none owed: addr %h ok %0d free %0d frames %0d",
                   $time, got.frame_address, got.success, got.free_count, got.frame_count);
        bad_replies++;
      end else begin
        want = replies_due.pop_front();
        if (got.frame_address !== want.frame_address || got.success !== want.success ||
            got.free_count !== want.free_count || got.frame_count !== want.frame_count) begin
          if (bad_replies < 10)
            $display("%0t: mismatch: exp %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                     $time, want.frame_address, want.success, want.free_count,
                     want.frame_count, got.frame_address, got.success, got.free_count,
                     got.frame_count);
          bad_replies++;
        end
      end
    end
  end

endmodule
